// ===== design/gelu_pkg.sv =====
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared types and constants for the GELU (tanh form) activation pipeline.
// ----------------------------------------------------------------------------
package gelu_pkg;

  localparam int GELU_DATA_WIDTH = 16;
  localparam int GELU_FRAC_BITS  = 12;

  // tanh datapath: Q.30 fractions, 32-bit divider words
  localparam int Q_BITS = 30;
  localparam int DIV_W  = Q_BITS + 2;
  localparam int N_W    = 4;

  localparam logic [Q_BITS:0] Q_ONE = (Q_BITS + 1)'(1) << Q_BITS;

  typedef struct packed {
    logic signed [GELU_DATA_WIDTH-1:0] sample;
    logic                              last;
  } gelu_req_t;

  typedef struct packed {
    logic signed [GELU_DATA_WIDTH-1:0] activation;
    logic                              last_out;
  } gelu_res_t;

  // sideband that travels with each request down the pipeline
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic                       neg;
    logic                       sat;
    logic [N_W-1:0]             n;
    logic [GELU_DATA_WIDTH-1:0] mag;
  } gelu_side_t;

endpackage

// ===== design/gelu_horner_step.sv =====
// ----------------------------------------------------------------------------
// gelu_horner_step
// One Horner step of the exp(-z) series: r' = 1 - floor(((z*r)>>30) / K).
// Three register stages: product, reciprocal multiply, correction.
// ----------------------------------------------------------------------------
module gelu_horner_step
  import gelu_pkg::*;
#(
  parameter int K = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  gelu_side_t        side_in,
  input  logic [Q_BITS-1:0] z_in,
  input  logic [Q_BITS:0]   r_in,
  output gelu_side_t        side_out,
  output logic [Q_BITS-1:0] z_out,
  output logic [Q_BITS:0]   r_out
);

  localparam int PW   = 2 * Q_BITS + 1;
  localparam int RW   = Q_BITS + 2;
  localparam int QP_W = Q_BITS + RW;
  localparam int CW   = Q_BITS + $clog2(K + 1);
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << (Q_BITS + 1)) / 64'(K));

  logic [PW-1:0]     prod;
  logic [QP_W-1:0]   qprod;
  logic [CW-1:0]     rem;
  logic [Q_BITS-1:0] q;

  gelu_side_t        side1, side2;
  logic [Q_BITS-1:0] z1, z2, p1, p2, q0;

  assign prod  = PW'(z_in) * PW'(r_in);
  assign qprod = QP_W'(p1) * QP_W'(RECIP);
  // reciprocal estimate is low by at most one
  assign rem   = CW'(p2) - CW'(q0) * CW'(K);
  assign q     = q0 + Q_BITS'(rem >= CW'(K));

  always_ff @(posedge clk) begin
    if (rst) begin
      side1    <= '0;
      side2    <= '0;
      side_out <= '0;
    end else begin
      side1    <= side_in;
      side2    <= side1;
      side_out <= side2;
    end
    z1    <= z_in;
    p1    <= prod[2*Q_BITS-1:Q_BITS];
    z2    <= z1;
    p2    <= p1;
    q0    <= qprod[2*Q_BITS:Q_BITS+1];
    z_out <= z2;
    r_out <= Q_ONE - (Q_BITS + 1)'(q);
  end

endmodule

// ===== design/gelu_div.sv =====
// ----------------------------------------------------------------------------
// gelu_div
// Pipelined restoring divider for tanh = (1-E)/(1+E) in Q.30.
// One quotient bit per stage; the starting remainder is below the divisor.
// ----------------------------------------------------------------------------
module gelu_div
  import gelu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  gelu_side_t        side_in,
  input  logic [DIV_W-1:0]  num_in,
  input  logic [DIV_W-1:0]  den_in,
  output gelu_side_t        side_out,
  output logic [Q_BITS-1:0] quo_out
);

  gelu_side_t        side_q [Q_BITS];
  logic [DIV_W-1:0]  rem_q  [Q_BITS];
  logic [DIV_W-1:0]  den_q  [Q_BITS];
  logic [Q_BITS-1:0] quo_q  [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    gelu_side_t        side_i;
    logic [DIV_W-1:0]  rem_i, den_i, shl;
    logic [Q_BITS-1:0] quo_i;
    logic              fit;

    if (i == 0) begin : g_first
      assign side_i = side_in;
      assign rem_i  = num_in;
      assign den_i  = den_in;
      assign quo_i  = '0;
    end else begin : g_next
      assign side_i = side_q[i-1];
      assign rem_i  = rem_q[i-1];
      assign den_i  = den_q[i-1];
      assign quo_i  = quo_q[i-1];
    end

    assign shl = {rem_i[DIV_W-2:0], 1'b0};
    assign fit = shl >= den_i;

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[i] <= '0;
      end else begin
        side_q[i] <= side_i;
      end
      rem_q[i]  <= fit ? (shl - den_i) : shl;
      den_q[i]  <= den_i;
      quo_q[i]  <= {quo_i[Q_BITS-2:0], fit};
    end
  end

  assign side_out = side_q[Q_BITS-1];
  assign quo_out  = quo_q[Q_BITS-1];

endmodule

// ===== design/gelu_tanh_activation.sv =====
// done strobes once per accepted request, after it leaves every stage.
// Throughput: one request per cycle, no bubbles; the 30-stage Horner chain
//   and the 30-stage divider are fully pipelined.
// busy is high only while rst is asserted; results are never held back.
// Reset (synchronous) clears every stage valid bit; data registers keep junk.
// ----------------------------------------------------------------------------
// gelu_tanh_activation
// GELU, tanh form, on signed fixed-point samples, rounded and saturated.
// ----------------------------------------------------------------------------
module gelu_tanh_activation
  import gelu_pkg::*;
#(
  parameter int FRAC_BITS = GELU_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  gelu_req_t request,
  output logic      busy,
  output logic      done,
  output gelu_res_t result
);

  localparam int DW         = GELU_DATA_WIDTH;
  localparam int AC_W       = FRAC_BITS + 3;
  localparam int CW         = (DW > AC_W) ? DW : AC_W;
  localparam int A16_FRAC   = 16;
  localparam int A16_W      = 19;
  localparam int SQ_W       = 21;
  localparam int CU_W       = 23;
  localparam int CT_W       = 18;
  localparam int U_W        = 19;
  localparam int K_FRAC     = 24;
  localparam int Y_SHIFT    = Q_BITS - A16_FRAC + 1;
  localparam int Y_W        = U_W - 1 + Y_SHIFT;
  localparam int N_MAX      = 11;
  localparam int HORNER_LEN = 10;
  localparam int PW         = DW + Q_BITS + 2;
  localparam int MW         = DW + 1;
  localparam int LAT        = 9 + 3 * HORNER_LEN + 1 + Q_BITS + 3;

  localparam logic [23:0]       C1_Q24  = 24'd13386282;
  localparam logic [19:0]       C2_Q24  = 20'd750193;
  localparam logic [Q_BITS-1:0] LN2_Q30 = 30'd744261118;
  localparam int                RND16   = 1 << (A16_FRAC - 1);
  localparam int                RND24   = 1 << (K_FRAC - 1);

  localparam logic [MW-1:0] MAXPOS = (MW'(1) << (DW - 1)) - MW'(1);
  localparam logic [MW-1:0] NEGLIM = MW'(1) << (DW - 1);

  logic          accept;
  logic [DW-1:0] samp_u;

  assign busy   = rst;
  assign accept = start && !busy;
  assign samp_u = request.sample;

  // stage 1: magnitude and sign
  gelu_side_t s1_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side <= '0;
    end else begin
      s1_side <= '{valid: accept, last: request.last, neg: samp_u[DW-1], sat: 1'b0,
                   n: '0, mag: samp_u[DW-1] ? (~samp_u + 1'b1) : samp_u};
    end
  end

  // stage 2: clamp to 4.0 and rescale to Q.16
  logic [CW-1:0]    a_ext, lim;
  logic [AC_W-1:0]  ac;
  logic [A16_W-1:0] a16_c;

  assign a_ext = CW'(s1_side.mag);
  assign lim   = CW'(4) << FRAC_BITS;
  assign ac    = AC_W'((a_ext > lim) ? lim : a_ext);

  if (FRAC_BITS > A16_FRAC) begin : g_down
    localparam int SH = FRAC_BITS - A16_FRAC;
    logic [AC_W:0] ac_rnd;
    assign ac_rnd = (AC_W + 1)'(ac) + ((AC_W + 1)'(1) << (SH - 1));
    assign a16_c  = A16_W'(ac_rnd >> SH);
  end else begin : g_up
    assign a16_c = A16_W'(ac) << (A16_FRAC - FRAC_BITS);
  end

  gelu_side_t       s2_side;
  logic [A16_W-1:0] s2_a16;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side <= '0;
    end else begin
      s2_side <= s1_side;
    end
    s2_a16 <= a16_c;
  end

  // stages 3..7: square, cube, cubic term, sum, inner argument u
  logic [2*A16_W-1:0]        sq_full;
  logic [SQ_W+A16_W-1:0]     cu_full;
  logic [CU_W+20-1:0]        ct_full;
  logic [A16_W+24-1:0]       u_full;

  gelu_side_t       s3_side, s4_side, s5_side, s6_side, s7_side;
  logic [A16_W-1:0] s3_a16, s4_a16, s5_a16, s6_sum;
  logic [SQ_W-1:0]  s3_sq;
  logic [CU_W-1:0]  s4_cu;
  logic [CT_W-1:0]  s5_ct;
  logic [U_W-1:0]   s7_u;

  assign sq_full = (2*A16_W)'(s2_a16) * (2*A16_W)'(s2_a16) + (2*A16_W)'(RND16);
  assign cu_full = (SQ_W+A16_W)'(s3_sq) * (SQ_W+A16_W)'(s3_a16) + (SQ_W+A16_W)'(RND16);
  assign ct_full = (CU_W+20)'(s4_cu) * (CU_W+20)'(C2_Q24) + (CU_W+20)'(RND24);
  assign u_full  = (A16_W+24)'(s6_sum) * (A16_W+24)'(C1_Q24) + (A16_W+24)'(RND24);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side <= '0;
      s4_side <= '0;
      s5_side <= '0;
      s6_side <= '0;
      s7_side <= '0;
    end else begin
      s3_side <= s2_side;
      s4_side <= s3_side;
      s5_side <= s4_side;
      s6_side <= s5_side;
      s7_side <= s6_side;
    end
    s3_a16 <= s2_a16;
    s3_sq  <= sq_full[A16_FRAC+SQ_W-1:A16_FRAC];
    s4_a16 <= s3_a16;
    s4_cu  <= cu_full[A16_FRAC+CU_W-1:A16_FRAC];
    s5_a16 <= s4_a16;
    s5_ct  <= ct_full[K_FRAC+CT_W-1:K_FRAC];
    s6_sum <= s5_a16 + A16_W'(s5_ct);
    s7_u   <= u_full[K_FRAC+U_W-1:K_FRAC];
  end

  // stage 8: y = 2u in Q.30, n = floor(y / ln2)
  logic [Y_W-1:0] y_c;
  logic [N_W-1:0] n_c;

  assign y_c = Y_W'(s7_u[U_W-2:0]) << Y_SHIFT;

  always_comb begin
    n_c = '0;
    for (int k = 1; k <= N_MAX; k++) begin
      if ((Y_W + 1)'(y_c) >= (Y_W + 1)'(k) * (Y_W + 1)'(LN2_Q30)) begin
        n_c = N_W'(k);
      end
    end
  end

  gelu_side_t     s8_side, s8_side_next;
  logic [Y_W-1:0] s8_y;

  always_comb begin
    s8_side_next     = s7_side;
    s8_side_next.sat = s7_u[U_W-1];
    s8_side_next.n   = n_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_side <= '0;
    end else begin
      s8_side <= s8_side_next;
    end
    s8_y <= y_c;
  end

  // stage 9: reduced argument z = y - n*ln2
  gelu_side_t        s9_side;
  logic [Q_BITS-1:0] s9_z;
  always_ff @(posedge clk) begin
    if (rst) begin
      s9_side <= '0;
    end else begin
      s9_side <= s8_side;
    end
    s9_z <= Q_BITS'(s8_y - Y_W'(s8_side.n) * Y_W'(LN2_Q30));
  end

  // exp(-z) by Horner, degree 10 down to 1
  gelu_side_t        h_side [HORNER_LEN+1];
  logic [Q_BITS-1:0] h_z    [HORNER_LEN+1];
  logic [Q_BITS:0]   h_r    [HORNER_LEN+1];

  assign h_side[0] = s9_side;
  assign h_z[0]    = s9_z;
  assign h_r[0]    = Q_ONE;

  for (genvar j = 0; j < HORNER_LEN; j++) begin : g_horner
    gelu_horner_step #(
      .K (HORNER_LEN - j)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .side_in  (h_side[j]),
      .z_in     (h_z[j]),
      .r_in     (h_r[j]),
      .side_out (h_side[j+1]),
      .z_out    (h_z[j+1]),
      .r_out    (h_r[j+1])
    );
  end

  // E = r >> n, then divider operands 1-E and 1+E
  logic [Q_BITS:0] e_c;
  assign e_c = h_r[HORNER_LEN] >> h_side[HORNER_LEN].n;

  gelu_side_t       se_side;
  logic [DIV_W-1:0] se_num, se_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      se_side <= '0;
    end else begin
      se_side <= h_side[HORNER_LEN];
    end
    se_num <= DIV_W'(Q_ONE) - DIV_W'(e_c);
    se_den <= DIV_W'(Q_ONE) + DIV_W'(e_c);
  end

  gelu_side_t        dv_side;
  logic [Q_BITS-1:0] dv_quo;

  gelu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .side_in  (se_side),
    .num_in   (se_num),
    .den_in   (se_den),
    .side_out (dv_side),
    .quo_out  (dv_quo)
  );

  // factor 1 + t or 1 - t, then scale by |x|
  logic [Q_BITS:0] t_c;
  assign t_c = dv_side.sat ? Q_ONE : (Q_BITS + 1)'(dv_quo);

  gelu_side_t       sf_side, sp_side;
  logic [DIV_W-1:0] sf_f;
  logic [PW-1:0]    sp_prod;
  always_ff @(posedge clk) begin
    if (rst) begin
      sf_side <= '0;
      sp_side <= '0;
    end else begin
      sf_side <= dv_side;
      sp_side <= sf_side;
    end
    sf_f    <= dv_side.neg ? (DIV_W'(Q_ONE) - DIV_W'(t_c)) : (DIV_W'(Q_ONE) + DIV_W'(t_c));
    sp_prod <= PW'(sf_side.mag) * PW'(sf_f);
  end

  // round, saturate, apply sign
  logic [PW-1:0] rnd_c;
  logic [MW-1:0] mag_c, mag_sat;
  logic [DW-1:0] act_c;

  assign rnd_c   = sp_prod + PW'(Q_ONE);
  assign mag_c   = MW'(rnd_c >> (Q_BITS + 1));
  assign mag_sat = sp_side.neg ? ((mag_c > NEGLIM) ? NEGLIM : mag_c)
                               : ((mag_c > MAXPOS) ? MAXPOS : mag_c);
  assign act_c   = sp_side.neg ? DW'(MW'(0) - mag_sat) : DW'(mag_sat);

  always_ff @(posedge clk) begin
    result.activation <= act_c;
    result.last_out   <= sp_side.last;
    done              <= !rst && sp_side.valid;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a request at the pipeline depth");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.last_out == $past(request.last, LAT)))
    else $error("last flag out of step with its request");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    (done && $past(request.sample[DW-1], LAT)) |->
      (result.activation[DW-1] || (result.activation == '0)))
    else $error("negative sample gave a positive result");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    (done && $past(!request.sample[DW-1] && (CW'(samp_u) >= lim), LAT)) |->
      (result.activation == $past(request.sample, LAT)))
    else $error("large positive sample not passed through");

endmodule
